[rtl/core/mer_pkg.sv]
// ----------------------------------------------------------------------------
// mer_pkg
// shared constants, command and status types of the midpoint ellipse engine
// ----------------------------------------------------------------------------
package mer_pkg;

    localparam int DEC_W    = 48;   // decision word, kept at four times scale
    localparam int CENTER_W = 11;   // signed center coordinate
    localparam int PT_W     = 12;   // signed point coordinate
    localparam int PTS_W    = 8 * PT_W;

    typedef enum logic [0:0] {
        FUNC_START   = 1'b0,
        FUNC_ADVANCE = 1'b1
    } func_t;

    // operand pair for the shared multiplier
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_RX_RX,
        MUL_RY_RY,
        MUL_RX2_Y,
        MUL_RY2_X,
        MUL_X21_SQ,
        MUL_RY2_P,
        MUL_YM1_SQ,
        MUL_RX2_P,
        MUL_RX2_RY2
    } mul_op_t;

    // what the accumulator does with the previous product
    typedef enum logic [3:0] {
        ACC_NONE,
        ACC_SAVE_RX2,
        ACC_SAVE_RY2,
        ACC_SAVE_TMP,
        ACC_DEC_START,
        ACC_LOAD,
        ACC_ADD4,
        ACC_SUB4,
        ACC_ADD8_RY2,
        ACC_SUB8_DIAG,
        ACC_SUB8_RX2,
        ACC_ADD8_DIAG
    } acc_op_t;

    typedef struct packed {
        logic    load;
        logic    step1;
        logic    step2;
        logic    set_r2;
        mul_op_t mul;
        acc_op_t acc;
        logic    emit;
        logic    emit_null;
    } dp_cmd_t;

    typedef struct packed {
        logic finished;
        logic region_two;
        logic le;
    } dp_sts_t;

endpackage

[rtl/core/midpoint_ellipse_rasterizer.sv]
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// two-region midpoint walk of an axis-aligned ellipse, four points per item
// ----------------------------------------------------------------------------
//
//  channel   dir   tdata                       tuser          tlast
//  s_axis    in    center, radii               func           -
//  m_axis    out   four quadrant points        points_valid   last
//
//  start, region-one and region-two steps and the step that crosses into
//  region two share one multiplier and its single product register
//  one item is in work at a time; s_axis_tready is high only when idle
//  the result sits in an output register, so the next item is taken while
//  it waits; a stalled m_axis only holds the engine at its emit or null-result step
//  rst_n is asynchronous, active low; after reset the walk counts as ended
//
module midpoint_ellipse_rasterizer #(
    parameter int RADIUS_BITS = 10
) (
    input  logic clk,
    input  logic rst_n,

    // center_x[10:0], center_y[21:11], radius_x, radius_y, zero fill to bytes
    input  logic [((2 * mer_pkg::CENTER_W + 2 * RADIUS_BITS + 7) / 8) * 8 - 1:0]
                 s_axis_tdata,
    input  logic s_axis_tuser,   // func
    input  logic s_axis_tvalid,
    output logic s_axis_tready,

    // pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y, pt4_x, pt4_y, 12 bits each
    output logic [mer_pkg::PTS_W-1:0] m_axis_tdata,
    output logic m_axis_tuser,   // points_valid
    output logic m_axis_tlast,   // last
    output logic m_axis_tvalid,
    input  logic m_axis_tready
);

    localparam int CW     = mer_pkg::CENTER_W;
    localparam int RB     = RADIUS_BITS;
    localparam int RX_LSB = 2 * CW;
    localparam int RY_LSB = 2 * CW + RB;

    mer_pkg::dp_cmd_t cmd;
    mer_pkg::dp_sts_t sts;

    logic signed [CW-1:0] center_x, center_y;
    logic [RB-1:0]        radius_x, radius_y;

    // field unpack, lowest field first
    assign center_x = s_axis_tdata[CW-1:0];
    assign center_y = s_axis_tdata[2*CW-1:CW];
    assign radius_x = s_axis_tdata[RX_LSB+RB-1:RX_LSB];
    assign radius_y = s_axis_tdata[RY_LSB+RB-1:RY_LSB];

    // sequencer: handshakes and step order
    mer_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .func      (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // offsets, decision word, multiplier and result register
    mer_datapath #(
        .RADIUS_BITS (RADIUS_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .center_x     (center_x),
        .center_y     (center_y),
        .radius_x     (radius_x),
        .radius_y     (radius_y),
        .pts          (m_axis_tdata),
        .last         (m_axis_tlast),
        .points_valid (m_axis_tuser)
    );

endmodule

[rtl/core/mer_datapath.sv]
// ----------------------------------------------------------------------------
// mer_datapath
// offsets, decision word, shared multiplier and the output register
// ----------------------------------------------------------------------------
module mer_datapath #(
    parameter int RADIUS_BITS = 10
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  mer_pkg::dp_cmd_t                       cmd,
    output mer_pkg::dp_sts_t                       sts,
    input  logic signed [mer_pkg::CENTER_W-1:0]    center_x,
    input  logic signed [mer_pkg::CENTER_W-1:0]    center_y,
    input  logic        [RADIUS_BITS-1:0]          radius_x,
    input  logic        [RADIUS_BITS-1:0]          radius_y,
    output logic        [mer_pkg::PTS_W-1:0]       pts,
    output logic                                   last,
    output logic                                   points_valid
);

    localparam int RB  = RADIUS_BITS;
    localparam int OPW = 2 * RB + 2;
    localparam int PW  = 2 * OPW;
    localparam int DW  = mer_pkg::DEC_W;
    localparam int PTW = mer_pkg::PT_W;
    localparam int XW  = RB + PTW;

    logic signed [mer_pkg::CENTER_W-1:0] cx_reg, cy_reg;
    logic [RB-1:0]     rx_reg, ry_reg;
    logic [RB-1:0]     x_reg, x_next, y_reg, y_next;
    logic [2*RB-1:0]   rx2_reg, ry2_reg;
    logic [DW-1:0]     prod_reg, tmp_reg, dec_reg, dec_next;
    logic              diag_reg, diag_next;
    logic              r2_reg, fin_reg, fin_next;
    logic [mer_pkg::PTS_W-1:0] pts_reg;
    logic              last_reg, pv_reg;

    logic [RB-1:0]     x_inc, y_dec, y_m1;
    logic [RB:0]       x21;
    logic [OPW-1:0]    mul_a, mul_b;
    logic [PW-1:0]     prod_full;
    logic [DW-1:0]     prod_new;
    logic [DW-1:0]     rx2_ext, ry2_ext;
    logic              dec_pos;

    // offset moves: x_inc and y_dec saturate, y_m1 wraps at zero
    assign x_inc   = (x_reg == {RB{1'b1}}) ? x_reg : x_reg + 1'b1;
    assign y_dec   = (y_reg == '0) ? y_reg : y_reg - 1'b1;
    assign y_m1    = y_reg - 1'b1;
    assign x21     = {x_reg, 1'b1};
    assign rx2_ext = DW'(rx2_reg);
    assign ry2_ext = DW'(ry2_reg);
    assign dec_pos = !dec_reg[DW-1] && (dec_reg != '0);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul)
            mer_pkg::MUL_RX_RX:   begin mul_a = OPW'(rx_reg);  mul_b = OPW'(rx_reg);  end
            mer_pkg::MUL_RY_RY:   begin mul_a = OPW'(ry_reg);  mul_b = OPW'(ry_reg);  end
            mer_pkg::MUL_RX2_Y:   begin mul_a = OPW'(rx2_reg); mul_b = OPW'(y_reg);   end
            mer_pkg::MUL_RY2_X:   begin mul_a = OPW'(ry2_reg); mul_b = OPW'(x_reg);   end
            mer_pkg::MUL_X21_SQ:  begin mul_a = OPW'(x21);     mul_b = OPW'(x21);     end
            mer_pkg::MUL_RY2_P:   begin mul_a = OPW'(ry2_reg); mul_b = prod_reg[OPW-1:0]; end
            mer_pkg::MUL_YM1_SQ:  begin mul_a = OPW'(y_m1);    mul_b = OPW'(y_m1);    end
            mer_pkg::MUL_RX2_P:   begin mul_a = OPW'(rx2_reg); mul_b = prod_reg[OPW-1:0]; end
            mer_pkg::MUL_RX2_RY2: begin mul_a = OPW'(rx2_reg); mul_b = OPW'(ry2_reg); end
            default:              begin mul_a = '0;            mul_b = '0;            end
        endcase
    end

    assign prod_full = mul_a * mul_b;

    generate
        if (PW >= DW) begin : g_prod_trunc
            assign prod_new = prod_full[DW-1:0];
        end else begin : g_prod_ext
            assign prod_new = {{(DW - PW){1'b0}}, prod_full};
        end
    endgenerate

    // decision update, products at four times scale
    always_comb
    begin
        dec_next = dec_reg;
        case (cmd.acc)
            mer_pkg::ACC_DEC_START: dec_next = (ry2_ext << 2) - (prod_reg << 2) + rx2_ext;
            mer_pkg::ACC_LOAD:      dec_next = prod_reg;
            mer_pkg::ACC_ADD4:      dec_next = dec_reg + (prod_reg << 2);
            mer_pkg::ACC_SUB4:      dec_next = dec_reg - (prod_reg << 2);
            mer_pkg::ACC_ADD8_RY2:  dec_next = dec_reg + (prod_reg << 3) + (ry2_ext << 2);
            mer_pkg::ACC_SUB8_DIAG: dec_next = diag_reg ? dec_reg - (prod_reg << 3) : dec_reg;
            mer_pkg::ACC_SUB8_RX2:  dec_next = dec_reg - (prod_reg << 3) + (rx2_ext << 2);
            mer_pkg::ACC_ADD8_DIAG: dec_next = diag_reg ? dec_reg + (prod_reg << 3) : dec_reg;
            default:                dec_next = dec_reg;
        endcase
    end

    // offset steps
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        diag_next = diag_reg;
        fin_next  = fin_reg;
        if (cmd.load)
        begin
            x_next   = '0;
            y_next   = radius_y;
            fin_next = (radius_y == '0);
        end
        else if (cmd.step1)
        begin
            x_next    = x_inc;
            diag_next = !dec_reg[DW-1];
            y_next    = dec_reg[DW-1] ? y_reg : y_dec;
            fin_next  = (y_next == '0);
        end
        else if (cmd.step2)
        begin
            diag_next = !dec_pos;
            x_next    = dec_pos ? x_reg : x_inc;
            y_next    = y_dec;
            fin_next  = (y_dec == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            y_reg    <= '0;
            rx_reg   <= '0;
            ry_reg   <= '0;
            cx_reg   <= '0;
            cy_reg   <= '0;
            r2_reg   <= 1'b0;
            fin_reg  <= 1'b1;
            diag_reg <= 1'b0;
        end
        else
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            fin_reg  <= fin_next;
            diag_reg <= diag_next;
            if (cmd.load)
            begin
                cx_reg <= center_x;
                cy_reg <= center_y;
                rx_reg <= radius_x;
                ry_reg <= radius_y;
                r2_reg <= 1'b0;
            end
            else if (cmd.set_r2)
            begin
                r2_reg <= 1'b1;
            end
        end
    end

    // point sums wrap to the point width
    logic [XW-1:0]  x_wide, y_wide;
    logic [PTW-1:0] xo, yo, cxe, cye;

    assign x_wide = XW'(x_reg);
    assign y_wide = XW'(y_reg);
    assign xo     = x_wide[PTW-1:0];
    assign yo     = y_wide[PTW-1:0];
    assign cxe    = PTW'(cx_reg);
    assign cye    = PTW'(cy_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.mul != mer_pkg::MUL_NONE)
            prod_reg <= prod_new;
        if (cmd.acc == mer_pkg::ACC_SAVE_RX2)
            rx2_reg <= prod_reg[2*RB-1:0];
        if (cmd.acc == mer_pkg::ACC_SAVE_RY2)
            ry2_reg <= prod_reg[2*RB-1:0];
        if (cmd.acc == mer_pkg::ACC_SAVE_TMP)
            tmp_reg <= prod_reg;
        dec_reg <= dec_next;
        if (cmd.emit)
        begin
            pts_reg  <= {cye - yo, cxe - xo, cye + yo, cxe - xo,
                         cye - yo, cxe + xo, cye + yo, cxe + xo};
            last_reg <= fin_reg;
            pv_reg   <= 1'b1;
        end
        else if (cmd.emit_null)
        begin
            pts_reg  <= '0;
            last_reg <= 1'b0;
            pv_reg   <= 1'b0;
        end
    end

    assign sts.finished   = fin_reg;
    assign sts.region_two = r2_reg;
    assign sts.le         = (tmp_reg <= prod_reg);

    assign pts          = pts_reg;
    assign last         = last_reg;
    assign points_valid = pv_reg;

`ifndef SYNTHESIS
    // y offset only walks down from the held radius
    a_y_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        y_reg <= ry_reg)
        else $error("y offset above held radius");

    // region-one steps never issue once the walk is in region two
    a_step1_region: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step1 |-> !r2_reg)
        else $error("region-one step in region two");
`endif

endmodule

[rtl/core/mer_ctrl.sv]
// ----------------------------------------------------------------------------
// mer_ctrl
// sequencer for start, region-one, region-two, handover and null-result steps
// ----------------------------------------------------------------------------
module mer_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             func,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  mer_pkg::dp_sts_t sts,
    output mer_pkg::dp_cmd_t cmd
);

    typedef enum logic [4:0] {
        IDLE,
        ST_RX2,
        ST_RY2,
        ST_RX2Y,
        ST_FIN,
        C1_B,
        C1_CMP,
        R1_MA,
        R1_MB,
        R1_FIN,
        R2S_B,
        R2S_C,
        R2S_D,
        R2S_E,
        R2S_F,
        R2_STEP,
        R2_MA,
        R2_MB,
        R2_FIN,
        EMIT,
        NULL_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   is_start;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == IDLE);
    assign is_start = (mer_pkg::func_t'(func) == mer_pkg::FUNC_START);

    always_comb
    begin
        state_next    = state_reg;
        cmd.load      = 1'b0;
        cmd.step1     = 1'b0;
        cmd.step2     = 1'b0;
        cmd.set_r2    = 1'b0;
        cmd.mul       = mer_pkg::MUL_NONE;
        cmd.acc       = mer_pkg::ACC_NONE;
        cmd.emit      = 1'b0;
        cmd.emit_null = 1'b0;
        case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    if (is_start)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_RX2;
                    end
                    else if (sts.finished)
                        state_next = NULL_OUT;
                    else if (sts.region_two)
                        state_next = R2_STEP;
                    else
                    begin
                        cmd.mul    = mer_pkg::MUL_RY2_X;
                        state_next = C1_B;
                    end
                end
            end
            ST_RX2:
            begin
                cmd.mul    = mer_pkg::MUL_RX_RX;
                state_next = ST_RY2;
            end
            ST_RY2:
            begin
                cmd.mul    = mer_pkg::MUL_RY_RY;
                cmd.acc    = mer_pkg::ACC_SAVE_RX2;
                state_next = ST_RX2Y;
            end
            ST_RX2Y:
            begin
                cmd.mul    = mer_pkg::MUL_RX2_Y;
                cmd.acc    = mer_pkg::ACC_SAVE_RY2;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.acc    = mer_pkg::ACC_DEC_START;
                cmd.emit   = out_free;
                state_next = out_free ? IDLE : EMIT;
            end
            C1_B:
            begin
                cmd.mul    = mer_pkg::MUL_RX2_Y;
                cmd.acc    = mer_pkg::ACC_SAVE_TMP;
                state_next = C1_CMP;
            end
            C1_CMP:
            begin
                if (sts.le)
                begin
                    cmd.step1  = 1'b1;
                    state_next = R1_MA;
                end
                else
                begin
                    cmd.mul    = mer_pkg::MUL_X21_SQ;
                    state_next = R2S_B;
                end
            end
            R1_MA:
            begin
                cmd.mul    = mer_pkg::MUL_RY2_X;
                state_next = R1_MB;
            end
            R1_MB:
            begin
                cmd.mul    = mer_pkg::MUL_RX2_Y;
                cmd.acc    = mer_pkg::ACC_ADD8_RY2;
                state_next = R1_FIN;
            end
            R1_FIN:
            begin
                cmd.acc    = mer_pkg::ACC_SUB8_DIAG;
                cmd.emit   = out_free;
                state_next = out_free ? IDLE : EMIT;
            end
            R2S_B:
            begin
                cmd.mul    = mer_pkg::MUL_RY2_P;
                state_next = R2S_C;
            end
            R2S_C:
            begin
                cmd.mul    = mer_pkg::MUL_YM1_SQ;
                cmd.acc    = mer_pkg::ACC_LOAD;
                state_next = R2S_D;
            end
            R2S_D:
            begin
                cmd.mul    = mer_pkg::MUL_RX2_P;
                state_next = R2S_E;
            end
            R2S_E:
            begin
                cmd.mul    = mer_pkg::MUL_RX2_RY2;
                cmd.acc    = mer_pkg::ACC_ADD4;
                state_next = R2S_F;
            end
            R2S_F:
            begin
                cmd.acc    = mer_pkg::ACC_SUB4;
                cmd.set_r2 = 1'b1;
                state_next = R2_STEP;
            end
            R2_STEP:
            begin
                cmd.step2  = 1'b1;
                state_next = R2_MA;
            end
            R2_MA:
            begin
                cmd.mul    = mer_pkg::MUL_RX2_Y;
                state_next = R2_MB;
            end
            R2_MB:
            begin
                cmd.mul    = mer_pkg::MUL_RY2_X;
                cmd.acc    = mer_pkg::ACC_SUB8_RX2;
                state_next = R2_FIN;
            end
            R2_FIN:
            begin
                cmd.acc    = mer_pkg::ACC_ADD8_DIAG;
                cmd.emit   = out_free;
                state_next = out_free ? IDLE : EMIT;
            end
            EMIT:
            begin
                cmd.emit   = out_free;
                state_next = out_free ? IDLE : EMIT;
            end
            NULL_OUT:
            begin
                cmd.emit_null = out_free;
                state_next    = out_free ? IDLE : NULL_OUT;
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit || cmd.emit_null)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    // one item at a time: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");

    // a result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit || cmd.emit_null |-> !out_valid_reg || out_ready)
        else $error("result overwritten");

    // region-two steps only once the handover has happened
    a_r2_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == R2_STEP |-> sts.region_two || $past(cmd.set_r2))
        else $error("region-two step before handover");
`endif

endmodule
